FILE: design/i2r_pkg.sv
// shared types, constants and helpers for the rotating i420 to rgb565 fetch
package i2r_pkg;

  localparam int OFS_W   = 20;
  localparam int ROW_W   = 10;
  localparam int COL_W   = 9;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 11;
  localparam int HGT_W   = 10;
  localparam int PIX_W   = 16;
  localparam int SUM_W   = 20;

  typedef enum logic [0:0] {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_e;

  typedef enum logic [0:0] {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } reg_e;

  localparam logic signed [SUM_W-1:0] CoefY   = 20'sd298;
  localparam logic signed [SUM_W-1:0] CoefRv  = 20'sd409;
  localparam logic signed [SUM_W-1:0] CoefGu  = 20'sd100;
  localparam logic signed [SUM_W-1:0] CoefGv  = 20'sd208;
  localparam logic signed [SUM_W-1:0] CoefBu  = 20'sd516;
  localparam logic signed [SUM_W-1:0] Round   = 20'sd128;
  localparam logic signed [9:0]       LumaOfs = 10'sd16;
  localparam logic signed [9:0]       ChromaOfs = 10'sd128;

  typedef struct packed {
    logic                req;
    logic [OFS_W-1:0]    offset;
    logic [BYTE_W-1:0]   value;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
  } item_t;

  typedef struct packed {
    logic valid;
    logic outside;
    logic czero;
  } meta_t;

  function automatic logic [7:0] clip8(logic signed [SUM_W-1:0] s);
    logic [7:0] r;
    if (s[SUM_W-1]) begin
      r = 8'd0;
    end else if (|s[SUM_W-2:16]) begin
      r = 8'hFF;
    end else begin
      r = s[15:8];
    end
    return r;
  endfunction

endpackage

FILE: design/i2r_ram.sv
// generic single port ram with registered read
module i2r_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: design/i2r_addr.sv
// address generation and plane decode in front of the three plane memories
module i2r_addr #(
  parameter int PANEL_W   = 480,
  parameter int PANEL_H   = 800,
  parameter int MAX_SRC_W = 1024,
  parameter int MAX_SRC_H = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  i2r_pkg::item_t        item_i,
  input  logic [$clog2(MAX_SRC_W+1)-1:0] w_i,
  input  logic [$clog2(MAX_SRC_H+1)-1:0] h_i,
  input  logic [$clog2(MAX_SRC_W+1)-1:0] cw_i,
  input  logic [$clog2(MAX_SRC_W*MAX_SRC_H*3/2+1)-1:0] plane_i,
  input  logic [$clog2(MAX_SRC_W*MAX_SRC_H*3/2+1)-1:0] pq_i,
  input  logic [$clog2(MAX_SRC_W*MAX_SRC_H*3/2+1)-1:0] end_i,
  output logic                  luma_we_o,
  output logic [$clog2(MAX_SRC_W*MAX_SRC_H)-1:0] luma_addr_o,
  output logic                  cb_we_o,
  output logic [$clog2(MAX_SRC_W*MAX_SRC_H/4)-1:0] cb_addr_o,
  output logic                  cr_we_o,
  output logic [$clog2(MAX_SRC_W*MAX_SRC_H/4)-1:0] cr_addr_o,
  output logic [i2r_pkg::BYTE_W-1:0] wdata_o,
  output i2r_pkg::meta_t        meta_o
);
  import i2r_pkg::*;

  localparam int WW   = $clog2(MAX_SRC_W+1);
  localparam int LumaDepth   = MAX_SRC_W * MAX_SRC_H;
  localparam int ChromaDepth = LumaDepth / 4;
  localparam int LAW  = $clog2(LumaDepth);
  localparam int CAW  = $clog2(ChromaDepth);
  localparam int EW   = $clog2(LumaDepth * 3 / 2 + 1);
  localparam int SYW  = $clog2(PANEL_W);
  localparam int MW   = (SYW + WW + 1 > LAW + 1) ? SYW + WW + 1 : LAW + 1;
  localparam int XW   = (EW > OFS_W) ? EW : OFS_W;

  logic           is_read;
  logic           in_luma, in_cb, in_cr;
  logic [SYW-1:0] sy;
  logic           outside;
  logic [MW-1:0]  li_full, ci_full;
  logic [XW-1:0]  off_x, cb_off, cr_off;
  meta_t          meta_d, meta_q;

  assign is_read = (item_i.req == REQ_READ);
  assign sy      = SYW'(PANEL_W - 1) - SYW'(item_i.col);

  assign outside = (int'(item_i.row) >= PANEL_H) || (int'(item_i.col) >= PANEL_W) ||
                   (int'(item_i.row) >= int'(w_i)) || (int'(sy) >= int'(h_i));

  assign li_full = MW'(sy) * MW'(w_i) + MW'(item_i.row);
  assign ci_full = MW'(sy >> 1) * MW'(cw_i) + MW'(item_i.row >> 1);

  assign off_x  = XW'(item_i.offset);
  assign cb_off = off_x - XW'(plane_i);
  assign cr_off = off_x - XW'(pq_i);

  assign in_luma = int'(item_i.offset) < int'(plane_i);
  assign in_cb   = !in_luma && (int'(item_i.offset) < int'(pq_i));
  assign in_cr   = !in_luma && !in_cb && (int'(item_i.offset) < int'(end_i));

  assign luma_we_o   = valid_i && !is_read && in_luma;
  assign cb_we_o     = valid_i && !is_read && in_cb;
  assign cr_we_o     = valid_i && !is_read && in_cr;
  assign luma_addr_o = is_read ? li_full[LAW-1:0] : off_x[LAW-1:0];
  assign cb_addr_o   = is_read ? ci_full[CAW-1:0] : cb_off[CAW-1:0];
  assign cr_addr_o   = is_read ? ci_full[CAW-1:0] : cr_off[CAW-1:0];
  assign wdata_o     = item_i.value;

  always_comb begin
    meta_d.valid   = valid_i && is_read;
    meta_d.outside = outside;
    meta_d.czero   = ci_full >= MW'(ChromaDepth);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else begin
      meta_q <= meta_d;
    end
  end

  assign meta_o = meta_q;

`ifndef ASSERT_OFF
  a_one_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({luma_we_o, cb_we_o, cr_we_o}))
    else $error("write decoded into more than one plane");
  a_meta_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_q.valid |-> $past(valid_i && is_read))
    else $error("read lookup without a read item");
`endif

endmodule

FILE: design/i2r_csc.sv
// bt.601 limited range color conversion and rgb565 packing
module i2r_csc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  i2r_pkg::meta_t             meta_i,
  input  logic [i2r_pkg::BYTE_W-1:0] y_i,
  input  logic [i2r_pkg::BYTE_W-1:0] u_i,
  input  logic [i2r_pkg::BYTE_W-1:0] v_i,
  output logic                       done_o,
  output logic [i2r_pkg::PIX_W-1:0]  rgb565_pixel_o,
  output logic                       outside_source_o
);
  import i2r_pkg::*;

  logic [BYTE_W-1:0]       u_eff, v_eff;
  logic signed [9:0]       c, d, e;
  logic signed [SUM_W-1:0] yc_d, rv_d, gu_d, gv_d, bu_d;
  logic signed [SUM_W-1:0] yc_q, rv_q, gu_q, gv_q, bu_q;
  logic signed [SUM_W-1:0] r_sum, g_sum, b_sum;
  logic [7:0]              r8, g8, b8;
  logic                    a_valid_q, a_out_q;
  logic                    done_q, out_q;
  logic [PIX_W-1:0]        pix_d, pix_q;

  // chroma lookups beyond the store read as zero
  assign u_eff = meta_i.czero ? '0 : u_i;
  assign v_eff = meta_i.czero ? '0 : v_i;

  assign c = $signed({2'b00, y_i})   - LumaOfs;
  assign d = $signed({2'b00, u_eff}) - ChromaOfs;
  assign e = $signed({2'b00, v_eff}) - ChromaOfs;

  assign yc_d = SUM_W'(c) * CoefY + Round;
  assign rv_d = SUM_W'(e) * CoefRv;
  assign gu_d = SUM_W'(d) * CoefGu;
  assign gv_d = SUM_W'(e) * CoefGv;
  assign bu_d = SUM_W'(d) * CoefBu;

  always_ff @(posedge clk_i) begin
    yc_q <= yc_d;
    rv_q <= rv_d;
    gu_q <= gu_d;
    gv_q <= gv_d;
    bu_q <= bu_d;
  end

  assign r_sum = yc_q + rv_q;
  assign g_sum = yc_q - gu_q - gv_q;
  assign b_sum = yc_q + bu_q;
  assign r8    = clip8(r_sum);
  assign g8    = clip8(g_sum);
  assign b8    = clip8(b_sum);
  assign pix_d = a_out_q ? '0 : {r8[7:3], g8[7:2], b8[7:3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      a_valid_q <= meta_i.valid;
      done_q    <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_out_q <= meta_i.outside;
    out_q   <= a_out_q;
    pix_q   <= pix_d;
  end

  assign done_o           = done_q;
  assign rgb565_pixel_o   = pix_q;
  assign outside_source_o = out_q;

endmodule

FILE: design/i420_to_rgb565_rotating_fetch.sv
// top level of the rotating i420 frame fetch with rgb565 output
//
// holds one planar i420 frame in three plane memories (y, u, v) and
// answers single panel pixels rotated by a quarter turn.
// command channel: an item transfers at a clock edge with start_i high
// and busy_o low. a write item stores byte_value_i at byte_offset_i of
// the packed buffer; a read item names panel_row_i / panel_col_i.
// each read gives one result, none for writes: done_o rises with
// rgb565_pixel_o and outside_source_o once the item has passed the
// input register, the memory read, the multiply register and the sum
// and clip register. one item is taken every clock while busy_o is
// low; the plane memories see one access per item, so reads after
// writes of the same byte see the new data.
// the config channel (cfg_valid_i/cfg_ready_o, index 0 width, 1 height)
// raises busy_o for one cycle after each transfer while the plane sizes
// are recomputed. the receiver cannot stall; results must be taken.
// reset sets the frame to 800x480 and clears the pipeline; plane
// contents are undefined until written.
module i420_to_rgb565_rotating_fetch #(
  parameter int PANEL_W   = 480,
  parameter int PANEL_H   = 800,
  parameter int MAX_SRC_W = 1024,
  parameter int MAX_SRC_H = 512
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       req_type_i,
  input  logic [i2r_pkg::OFS_W-1:0]  byte_offset_i,
  input  logic [i2r_pkg::BYTE_W-1:0] byte_value_i,
  input  logic [i2r_pkg::ROW_W-1:0]  panel_row_i,
  input  logic [i2r_pkg::COL_W-1:0]  panel_col_i,
  output logic                       done_o,
  output logic [i2r_pkg::PIX_W-1:0]  rgb565_pixel_o,
  output logic                       outside_source_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [i2r_pkg::CFG_W-1:0]  cfg_data_i
);
  import i2r_pkg::*;

  localparam int WW          = $clog2(MAX_SRC_W+1);
  localparam int HW          = $clog2(MAX_SRC_H+1);
  localparam int LumaDepth   = MAX_SRC_W * MAX_SRC_H;
  localparam int ChromaDepth = LumaDepth / 4;
  localparam int LAW         = $clog2(LumaDepth);
  localparam int CAW         = $clog2(ChromaDepth);
  localparam int EW          = $clog2(LumaDepth * 3 / 2 + 1);
  localparam int RstW        = (800 > MAX_SRC_W) ? MAX_SRC_W : 800;
  localparam int RstH        = (480 > MAX_SRC_H) ? MAX_SRC_H : 480;
  localparam int RstPlane    = RstW * RstH;
  localparam int RstQ        = RstPlane / 4;

  logic [CFG_W-1:0] src_w_q, src_w_d;
  logic [HGT_W-1:0] src_h_q, src_h_d;
  logic             upd_q;
  logic             cfg_xfer, accept;
  logic [WW-1:0]    eff_w, w_q, cw_q;
  logic [HW-1:0]    eff_h, h_q;
  logic [EW-1:0]    plane_d, pq_d, end_d, plane_q, pq_q, end_q;
  item_t            item_q;
  logic             s1_valid_q;
  meta_t            meta;
  logic             luma_we, cb_we, cr_we;
  logic [LAW-1:0]   luma_addr;
  logic [CAW-1:0]   cb_addr, cr_addr;
  logic [BYTE_W-1:0] wdata, y_rd, u_rd, v_rd;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign busy_o      = upd_q;
  assign accept      = start_i && !busy_o;

  always_comb begin
    src_w_d = src_w_q;
    src_h_d = src_h_q;
    if (cfg_xfer) begin
      unique case (cfg_index_i)
        REG_SRC_WIDTH:  src_w_d = cfg_data_i;
        REG_SRC_HEIGHT: src_h_d = cfg_data_i[HGT_W-1:0];
      endcase
    end
  end

  // dimensions clamped to the supported range
  always_comb begin
    if (src_w_q < CFG_W'(2)) begin
      eff_w = WW'(2);
    end else if (int'(src_w_q) > MAX_SRC_W) begin
      eff_w = WW'(MAX_SRC_W);
    end else begin
      eff_w = WW'(src_w_q);
    end
    if (src_h_q < HGT_W'(2)) begin
      eff_h = HW'(2);
    end else if (int'(src_h_q) > MAX_SRC_H) begin
      eff_h = HW'(MAX_SRC_H);
    end else begin
      eff_h = HW'(src_h_q);
    end
  end

  assign plane_d = EW'(eff_w) * EW'(eff_h);
  assign pq_d    = plane_d + (plane_d >> 2);
  assign end_d   = pq_d + (plane_d >> 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q    <= CFG_W'(800);
      src_h_q    <= HGT_W'(480);
      upd_q      <= 1'b0;
      w_q        <= WW'(RstW);
      h_q        <= HW'(RstH);
      cw_q       <= WW'(RstW / 2);
      plane_q    <= EW'(RstPlane);
      pq_q       <= EW'(RstPlane + RstQ);
      end_q      <= EW'(RstPlane + 2 * RstQ);
      s1_valid_q <= 1'b0;
    end else begin
      src_w_q    <= src_w_d;
      src_h_q    <= src_h_d;
      upd_q      <= cfg_xfer;
      s1_valid_q <= accept;
      if (upd_q) begin
        w_q     <= eff_w;
        h_q     <= eff_h;
        cw_q    <= eff_w >> 1;
        plane_q <= plane_d;
        pq_q    <= pq_d;
        end_q   <= end_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.req    <= req_type_i;
      item_q.offset <= byte_offset_i;
      item_q.value  <= byte_value_i;
      item_q.row    <= panel_row_i;
      item_q.col    <= panel_col_i;
    end
  end

  i2r_addr #(
    .PANEL_W  (PANEL_W),
    .PANEL_H  (PANEL_H),
    .MAX_SRC_W(MAX_SRC_W),
    .MAX_SRC_H(MAX_SRC_H)
  ) u_addr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_valid_q),
    .item_i     (item_q),
    .w_i        (w_q),
    .h_i        (h_q),
    .cw_i       (cw_q),
    .plane_i    (plane_q),
    .pq_i       (pq_q),
    .end_i      (end_q),
    .luma_we_o  (luma_we),
    .luma_addr_o(luma_addr),
    .cb_we_o    (cb_we),
    .cb_addr_o  (cb_addr),
    .cr_we_o    (cr_we),
    .cr_addr_o  (cr_addr),
    .wdata_o    (wdata),
    .meta_o     (meta)
  );

  i2r_ram #(.WIDTH(BYTE_W), .DEPTH(LumaDepth)) u_luma (
    .clk_i  (clk_i),
    .we_i   (luma_we),
    .addr_i (luma_addr),
    .wdata_i(wdata),
    .rdata_o(y_rd)
  );

  i2r_ram #(.WIDTH(BYTE_W), .DEPTH(ChromaDepth)) u_cb (
    .clk_i  (clk_i),
    .we_i   (cb_we),
    .addr_i (cb_addr),
    .wdata_i(wdata),
    .rdata_o(u_rd)
  );

  i2r_ram #(.WIDTH(BYTE_W), .DEPTH(ChromaDepth)) u_cr (
    .clk_i  (clk_i),
    .we_i   (cr_we),
    .addr_i (cr_addr),
    .wdata_i(wdata),
    .rdata_o(v_rd)
  );

  i2r_csc u_csc (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .meta_i          (meta),
    .y_i             (y_rd),
    .u_i             (u_rd),
    .v_i             (v_rd),
    .done_o          (done_o),
    .rgb565_pixel_o  (rgb565_pixel_o),
    .outside_source_o(outside_source_o)
  );

`ifndef ASSERT_OFF
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept && (req_type_i == REQ_READ), 4))
    else $error("result without a read transfer");
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && outside_source_o |-> rgb565_pixel_o == '0)
    else $error("pixel not zero outside the frame");
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_xfer |=> busy_o)
    else $error("no busy cycle after a config transfer");
`endif

endmodule

FILE: sim/tb_i420_to_rgb565_rotating_fetch.sv
// self-checking testbench for the rotating i420 frame fetch with rgb565 output
module tb_i420_to_rgb565_rotating_fetch;
  import i2r_pkg::*;

  localparam int PANEL_W     = 480;
  localparam int PANEL_H     = 800;
  localparam int MAX_SRC_W   = 1024;
  localparam int MAX_SRC_H   = 512;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 68;
  localparam int NUM_PHASES  = 8;
  localparam int unsigned PHASE_W[NUM_PHASES-1] = '{2047, 0, 7, 1024, 33, 2, 640};
  localparam int unsigned PHASE_H[NUM_PHASES-1] = '{1023, 1, 5, 2, 17, 512, 360};

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             outside;
  } pixel_t;

  class pixel_predictor;
    int unsigned src_w = 800;
    int unsigned src_h = 480;
    logic [7:0]  luma_mem[int unsigned];
    logic [7:0]  cb_mem[int unsigned];
    logic [7:0]  cr_mem[int unsigned];
    pixel_t      expected_pixels[$];
    int          errors = 0;

    function int unsigned eff_w();
      if (src_w < 2) return 2;
      if (src_w > MAX_SRC_W) return MAX_SRC_W;
      return src_w;
    endfunction

    function int unsigned eff_h();
      if (src_h < 2) return 2;
      if (src_h > MAX_SRC_H) return MAX_SRC_H;
      return src_h;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void set_reg(reg_e idx, int unsigned val);
      if (idx == REG_SRC_WIDTH) src_w = val & 32'h7FF;
      else src_h = val & 32'h3FF;
    endfunction

    function bit ready_at(int unsigned sx, int unsigned sy);
      int unsigned w, li, ci;
      w  = eff_w();
      li = sy * w + sx;
      ci = (sy / 2) * (w / 2) + sx / 2;
      return luma_mem.exists(li) && cb_mem.exists(ci) && cr_mem.exists(ci);
    endfunction

    function logic [7:0] sat8(int acc);
      if (acc < 0) return 8'd0;
      acc = acc / 256;
      if (acc > 255) return 8'hFF;
      return acc[7:0];
    endfunction

    // returns 1 when the item stored a byte or asked for a pixel
    function bit take_item(req_e req, logic [OFS_W-1:0] ofs, logic [BYTE_W-1:0] val,
                           logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
      int unsigned w, h, plane, q, sx, sy, li, ci;
      int          c, d, e;
      logic [7:0]  r, g, b;
      w     = eff_w();
      h     = eff_h();
      plane = w * h;
      q     = plane / 4;
      if (req == REQ_WRITE) begin
        if (ofs < plane) luma_mem[ofs] = val;
        else if (ofs - plane < q) cb_mem[ofs - plane] = val;
        else if (ofs - plane - q < q) cr_mem[ofs - plane - q] = val;
        else return 1'b0;
        return 1'b1;
      end
      if (row >= PANEL_H || col >= PANEL_W) begin
        expected_pixels.push_back('{'0, 1'b1});
        return 1'b1;
      end
      sx = row;
      sy = PANEL_W - 1 - col;
      if (sx >= w || sy >= h) begin
        expected_pixels.push_back('{'0, 1'b1});
        return 1'b1;
      end
      li = sy * w + sx;
      ci = (sy / 2) * (w / 2) + sx / 2;
      c  = int'(luma_mem[li]) - 16;
      d  = int'(cb_mem[ci]) - 128;
      e  = int'(cr_mem[ci]) - 128;
      r  = sat8(298 * c + 409 * e + 128);
      g  = sat8(298 * c - 100 * d - 208 * e + 128);
      b  = sat8(298 * c + 516 * d + 128);
      expected_pixels.push_back('{{r[7:3], g[7:2], b[7:3]}, 1'b0});
      return 1'b1;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_pixel(logic [PIX_W-1:0] pixel, logic outside);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", pixel));
        return;
      end
      want = expected_pixels.pop_front();
      if (pixel !== want.pixel)
        report_mismatch($sformatf("pixel %h, expected %h", pixel, want.pixel));
      if (outside !== want.outside)
        report_mismatch($sformatf("outside %b, expected %b", outside, want.outside));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic                req_type_i;
  logic [OFS_W-1:0]    byte_offset_i;
  logic [BYTE_W-1:0]   byte_value_i;
  logic [ROW_W-1:0]    panel_row_i;
  logic [COL_W-1:0]    panel_col_i;
  logic                done_o;
  logic [PIX_W-1:0]    rgb565_pixel_o;
  logic                outside_source_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_index_i;
  logic [CFG_W-1:0]    cfg_data_i;

  pixel_predictor pred = new();
  int             useful_items;
  int             gap_odds;
  int             cycles;
  int unsigned    ready_x[$];
  int unsigned    ready_y[$];

  i420_to_rgb565_rotating_fetch #(
    .PANEL_W  (PANEL_W),
    .PANEL_H  (PANEL_H),
    .MAX_SRC_W(MAX_SRC_W),
    .MAX_SRC_H(MAX_SRC_H)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .req_type_i      (req_type_i),
    .byte_offset_i   (byte_offset_i),
    .byte_value_i    (byte_value_i),
    .panel_row_i     (panel_row_i),
    .panel_col_i     (panel_col_i),
    .done_o          (done_o),
    .rgb565_pixel_o  (rgb565_pixel_o),
    .outside_source_o(outside_source_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) pred.check_pixel(rgb565_pixel_o, outside_source_o);
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(req_e req, logic [OFS_W-1:0] ofs, logic [BYTE_W-1:0] val,
                           logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    req_type_i    <= req;
    byte_offset_i <= ofs;
    byte_value_i  <= val;
    panel_row_i   <= row;
    panel_col_i   <= col;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (pred.take_item(req, ofs, val, row, col)) useful_items++;
  endtask

  task automatic send_write(int unsigned ofs, logic [7:0] val);
    send_item(REQ_WRITE, ofs[OFS_W-1:0], val, ROW_W'($urandom_range(0, 1023)),
              COL_W'($urandom_range(0, 511)));
  endtask

  task automatic send_read(int unsigned row, int unsigned col);
    send_item(REQ_READ, OFS_W'($urandom_range(0, 20'hFFFFF)), BYTE_W'($urandom_range(0, 255)),
              row[ROW_W-1:0], col[COL_W-1:0]);
  endtask

  // luma, then chroma unless skipped; the read goes out only once all three bytes exist
  task automatic send_pixel(int unsigned sx, int unsigned sy, logic [7:0] yv, logic [7:0] uv,
                            logic [7:0] vv, bit with_chroma);
    int unsigned w, plane, q, ci;
    w     = pred.eff_w();
    plane = w * pred.eff_h();
    q     = plane / 4;
    ci    = (sy / 2) * (w / 2) + sx / 2;
    send_write(sy * w + sx, yv);
    if (with_chroma && ci < q) begin
      send_write(plane + ci, uv);
      send_write(plane + q + ci, vv);
    end
    if (pred.ready_at(sx, sy)) begin
      send_read(sx, PANEL_W - 1 - sy);
      ready_x.push_back(sx);
      ready_y.push_back(sy);
    end
  endtask

  task automatic send_outside_read();
    int unsigned w, h, kind;
    w    = pred.eff_w();
    h    = pred.eff_h();
    kind = $urandom_range(0, 3);
    if (kind == 2 && w < PANEL_H)
      send_read($urandom_range(w, PANEL_H - 1), $urandom_range(0, PANEL_W - 1));
    else if (kind == 3 && h < PANEL_W)
      send_read($urandom_range(0, PANEL_H - 1), $urandom_range(0, PANEL_W - 1 - h));
    else if (kind[0])
      send_read($urandom_range(0, 1023), $urandom_range(PANEL_W, 511));
    else
      send_read($urandom_range(PANEL_H, 1023), $urandom_range(0, 511));
  endtask

  task automatic write_reg(reg_e idx, int unsigned val);
    start_i <= 1'b0;
    while (pred.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CFG_W-1:0];
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    pred.set_reg(idx, val);
  endtask

  initial begin
    int unsigned plane, q, goal, pick, idx, maxx, maxy;
    rst_ni        <= 1'b0;
    start_i       <= 1'b0;
    req_type_i    <= REQ_WRITE;
    byte_offset_i <= '0;
    byte_value_i  <= '0;
    panel_row_i   <= '0;
    panel_col_i   <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_SRC_WIDTH;
    cfg_data_i    <= '0;
    gap_odds      = 0;
    useful_items  = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners of the default 800x480 frame, clipping at both ends
    send_pixel(0, 0, 8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(799, 479, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(1, 1, 8'd16, 8'h00, 8'h00, 1'b0);
    send_pixel(2, 0, 8'd235, 8'd128, 8'd128, 1'b1);
    // chroma entries that odd frame sizes later reach past their planes
    plane = pred.eff_w() * pred.eff_h();
    q     = plane / 4;
    for (int k = 8; k < 10; k++) begin
      send_write(plane + k, pick_byte());
      send_write(plane + q + k, pick_byte());
    end
    send_read(1023, 0);
    send_read(0, 511);
    send_read(PANEL_H, PANEL_W);
    send_write(786431, 8'hA5);
    send_write(plane + 2 * q, 8'h5A);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        if ($urandom_range(0, 1)) begin
          write_reg(REG_SRC_WIDTH, PHASE_W[p-1]);
          write_reg(REG_SRC_HEIGHT, PHASE_H[p-1]);
        end else begin
          write_reg(REG_SRC_HEIGHT, PHASE_H[p-1]);
          write_reg(REG_SRC_WIDTH, PHASE_W[p-1]);
        end
        ready_x.delete();
        ready_y.delete();
      end
      gap_odds = (p == NUM_PHASES - 1) ? 0 : $urandom_range(0, 4);
      maxx     = (pred.eff_w() < PANEL_H) ? pred.eff_w() : PANEL_H;
      maxy     = (pred.eff_h() < PANEL_W) ? pred.eff_h() : PANEL_W;
      goal     = useful_items + PHASE_ITEMS;
      while (useful_items < goal) begin
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
          send_pixel($urandom_range(0, maxx - 1), $urandom_range(0, maxy - 1),
                     pick_byte(), pick_byte(), pick_byte(), $urandom_range(0, 3) != 0);
        end else if (pick < 13 && ready_x.size() != 0) begin
          idx = $urandom_range(0, ready_x.size() - 1);
          send_read(ready_x[idx], PANEL_W - 1 - ready_y[idx]);
        end else if (pick < 16) begin
          send_outside_read();
        end else begin
          send_write($urandom_range(0, 786431), pick_byte());
        end
      end
    end

    start_i <= 1'b0;
    while (pred.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pred.pending() != 0) pred.report_mismatch("results still missing at the end");
    if (pred.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
